// File: src/onfet_pkg.sv
// shared types and constants for the orbit number from epoch table unit
// field widths, result status codes, register indexes, control/status structs
// no dependencies
`default_nettype none
package onfet_pkg;

	localparam int YEAR_W   = 12;
	localparam int TIME_W   = 48;
	localparam int PER_W    = 29;
	localparam int ORB_W    = 32;
	localparam int USED_W   = 6;
	localparam int STALE_W  = 16;
	localparam int LIM_W    = 33;
	localparam int SUM_W    = 50;
	localparam int DCNT_W   = 6;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;
	localparam int IN_DW    = 176;
	localparam int OUT_DW   = 40;
	localparam int STAT_W   = 3;

	localparam logic [LIM_W-1:0]  SEC_PER_DAY = LIM_W'(86400);
	localparam logic [DCNT_W-1:0] DIV_LAST    = DCNT_W'(TIME_W - 1);

	localparam logic [YEAR_W-1:0]  MIN_YEAR_RST = YEAR_W'(1997);
	localparam logic [YEAR_W-1:0]  MAX_YEAR_RST = YEAR_W'(2020);
	localparam logic [STALE_W-1:0] STALE_RST    = STALE_W'(180);

	typedef enum logic [CIDX_W-1:0] {
		CFG_MIN_YEAR = 2'd0,
		CFG_MAX_YEAR = 2'd1,
		CFG_STALE    = 2'd2
	} cfg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_STORED  = 3'd0,
		STAT_DROPPED = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_ORBIT   = 3'd3,
		STAT_EMPTY   = 3'd4
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] epoch;
		logic [PER_W-1:0]  period;
		logic [ORB_W-1:0]  orbit;
	} rec_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic search;
		logic select;
		logic fetch;
		logic div_step;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic empty;
		logic single;
		logic found;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

// File: src/onfet_ctrl.sv
// sequencer for load, table search, divide and result handoff
// depends on onfet_pkg (cmd_t, stat_t)
`default_nettype none
module onfet_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire onfet_pkg::stat_t st,
	output onfet_pkg::cmd_t     cmd
);
	import onfet_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_SELECT,
		S_FETCH,
		S_DIVIDE,
		S_OUTPUT
	} state_t;

	state_t state_q;
	logic   out_vld_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.decode   = (state_q == S_DECODE);
		cmd.search   = (state_q == S_SEARCH);
		cmd.select   = (state_q == S_SELECT);
		cmd.fetch    = (state_q == S_FETCH);
		cmd.div_step = (state_q == S_DIVIDE);
		cmd.ld_out   = (state_q == S_OUTPUT) && (!out_vld_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= cmd.ld_out || (out_vld_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (!st.mode || st.empty)
						state_q <= S_OUTPUT;
					else if (st.single)
						state_q <= S_SELECT;
					else
						state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (st.found)
						state_q <= S_SELECT;
				end
				S_SELECT: state_q <= S_FETCH;
				S_FETCH:  state_q <= S_DIVIDE;
				S_DIVIDE: begin
					if (st.div_done)
						state_q <= S_OUTPUT;
				end
				S_OUTPUT: begin
					if (!out_vld_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/onfet_dp.sv
// datapath: config registers, record table memory, search compare,
// restoring divider, saturating sum and output register
// depends on onfet_pkg
`default_nettype none
module onfet_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [onfet_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [onfet_pkg::CDATA_W-1:0]  cfg_wdata,
	input  wire logic                           in_mode,
	input  wire logic [onfet_pkg::YEAR_W-1:0]   in_year,
	input  wire logic [onfet_pkg::TIME_W-1:0]   in_epoch,
	input  wire logic [onfet_pkg::PER_W-1:0]    in_period,
	input  wire logic [onfet_pkg::ORB_W-1:0]    in_orbit,
	input  wire logic [onfet_pkg::TIME_W-1:0]   in_qtime,
	input  wire onfet_pkg::cmd_t                cmd,
	output onfet_pkg::stat_t                    st,
	output onfet_pkg::status_t                  out_status,
	output logic signed [onfet_pkg::ORB_W-1:0]  out_orbit,
	output logic [onfet_pkg::USED_W-1:0]        out_used,
	output logic                                out_stale
);
	import onfet_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [YEAR_W-1:0]  min_year_q, max_year_q;
	logic [STALE_W-1:0] stale_lim_q;
	logic [LIM_W-1:0]   lim_q;

	logic               mode_q;
	logic [YEAR_W-1:0]  year_q;
	logic [TIME_W-1:0]  epoch_in_q, qtime_q;
	logic [PER_W-1:0]   period_in_q;
	logic [ORB_W-1:0]   orbit_in_q;

	rec_t               mem [TABLE_DEPTH];
	rec_t               rd_q;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      last_idx;
	logic [AW-1:0]      ptr_q, idx_q, chk_idx_s1;
	logic               chk_vld_s1;
	logic               hit, found;

	status_t            res_status_q;
	logic [USED_W-1:0]  used_q;

	logic               neg_q;
	logic [TIME_W-1:0]  mag_q, dvd_q;
	logic [PER_W-1:0]   per_q, rem_q;
	logic [ORB_W-1:0]   orb_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [PER_W:0]     trial;
	logic [PER_W+1:0]   diff;
	logic               ge;

	logic               full, year_ok;
	logic [SUM_W-1:0]   orb_ext, quot_ext, sum;
	logic               sat_hi, sat_lo, stale_now;
	logic [ORB_W-1:0]   sat_sum;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q  <= MIN_YEAR_RST;
			max_year_q  <= MAX_YEAR_RST;
			stale_lim_q <= STALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_YEAR: min_year_q  <= cfg_wdata[YEAR_W-1:0];
				CFG_MAX_YEAR: max_year_q  <= cfg_wdata[YEAR_W-1:0];
				CFG_STALE:    stale_lim_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk)
		lim_q <= LIM_W'(stale_lim_q) * SEC_PER_DAY;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q      <= in_mode;
			year_q      <= in_year;
			epoch_in_q  <= in_epoch;
			period_in_q <= in_period;
			orbit_in_q  <= in_orbit;
			qtime_q     <= in_qtime;
		end
	end

	assign full     = (count_q >= CW'(TABLE_DEPTH));
	assign year_ok  = (year_q >= min_year_q) && (year_q <= max_year_q);
	assign wr_en    = cmd.decode && !mode_q && !full && year_ok;
	assign last_idx = count_q - CW'(1);

	// record table
	assign rd_addr = cmd.select ? idx_q : ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[AW-1:0]] <= '{epoch: epoch_in_q, period: period_in_q,
				orbit: orbit_in_q};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (wr_en)
			count_q <= count_q + CW'(1);
	end

	// search for the first later epoch
	assign hit   = (qtime_q < rd_q.epoch);
	assign found = cmd.search && chk_vld_s1 && (hit || (CW'(chk_idx_s1) == last_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chk_vld_s1 <= 1'b0;
		else
			chk_vld_s1 <= cmd.search && !found;
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			ptr_q <= AW'(1);
			idx_q <= AW'(last_idx);
		end else if (cmd.search) begin
			ptr_q      <= ptr_q + AW'(1);
			chk_idx_s1 <= ptr_q;
			if (found && hit)
				idx_q <= chk_idx_s1 - AW'(1);
		end
	end

	// result code for the item
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			used_q <= '0;
			if (!mode_q) begin
				if (full)
					res_status_q <= STAT_FULL;
				else if (!year_ok)
					res_status_q <= STAT_DROPPED;
				else begin
					res_status_q <= STAT_STORED;
					used_q       <= USED_W'(count_q[AW-1:0]);
				end
			end else if (count_q == '0)
				res_status_q <= STAT_EMPTY;
			else
				res_status_q <= STAT_ORBIT;
		end
	end

	// delta and restoring divide
	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, per_q};
	assign ge    = !diff[PER_W+1];

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			neg_q  <= (qtime_q < rd_q.epoch);
			mag_q  <= (qtime_q < rd_q.epoch) ? (rd_q.epoch - qtime_q) : (qtime_q - rd_q.epoch);
			dvd_q  <= (qtime_q < rd_q.epoch) ? (rd_q.epoch - qtime_q) : (qtime_q - rd_q.epoch);
			per_q  <= rd_q.period;
			orb_q  <= rd_q.orbit;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
			dvd_q  <= {dvd_q[TIME_W-2:0], ge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	// final sum with saturation
	assign orb_ext  = {{(SUM_W-ORB_W){orb_q[ORB_W-1]}}, orb_q};
	assign quot_ext = {{(SUM_W-TIME_W){1'b0}}, dvd_q};
	assign sum      = neg_q ? (orb_ext + ~quot_ext) : (orb_ext + quot_ext);
	assign sat_hi   = !sum[SUM_W-1] && (|sum[SUM_W-2:ORB_W-1]);
	assign sat_lo   = sum[SUM_W-1] && !(&sum[SUM_W-2:ORB_W-1]);
	assign sat_sum  = sat_hi ? {1'b0, {(ORB_W-1){1'b1}}} :
		sat_lo ? {1'b1, {(ORB_W-1){1'b0}}} : sum[ORB_W-1:0];
	assign stale_now = !neg_q && ({1'b0, mag_q} > {lim_q, 16'h0000});

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_status <= res_status_q;
			if (res_status_q == STAT_ORBIT) begin
				out_orbit <= sat_sum;
				out_used  <= USED_W'(idx_q);
				out_stale <= stale_now;
			end else begin
				out_orbit <= '0;
				out_used  <= used_q;
				out_stale <= 1'b0;
			end
		end
	end

	always_comb begin
		st          = '0;
		st.mode     = mode_q;
		st.empty    = (count_q == '0);
		st.single   = (count_q == CW'(1));
		st.found    = found;
		st.div_done = cmd.div_step && (dcnt_q == DIV_LAST);
	end

endmodule
`default_nettype wire

// File: src/orbit_number_from_epoch_table_unit.sv
// top level of the orbit number from epoch table unit
// depends on onfet_pkg, onfet_ctrl, onfet_dp
`default_nettype none
// Keeps up to TABLE_DEPTH orbit records (epoch UQ32.16 s, period UQ13.16 s,
// orbit number) and turns a query time into an orbit number. One item is
// worked on at a time. A load goes from acceptance to the output register
// through the decode and output states. A query searches the table entries
// after the first linearly, reading one entry per cycle from the single read
// port of the table memory, and the restoring divider then retires one
// quotient bit per cycle. The next item is accepted as soon as a result sits
// in the output register. Table contents are not cleared at reset; only the
// record count is, so no clearing pass is needed.
module orbit_number_from_epoch_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [onfet_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [onfet_pkg::CDATA_W-1:0]  cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// record_year, entry_epoch, entry_period, entry_orbit, query_time, zero pad
	input  wire logic [onfet_pkg::IN_DW-1:0]    s_tdata,
	// mode
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// orbit_number, used_entry, stale, zero pad
	output logic [onfet_pkg::OUT_DW-1:0]        m_tdata,
	// status
	output logic [onfet_pkg::STAT_W-1:0]        m_tuser
);
	import onfet_pkg::*;

	cmd_t              cmd;
	stat_t             st;
	status_t           out_status;
	logic [ORB_W-1:0]  out_orbit;
	logic [USED_W-1:0] out_used;
	logic              out_stale;

	onfet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.st        (st),
		.cmd       (cmd)
	);

	onfet_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_mode    (s_tuser),
		.in_year    (s_tdata[11:0]),
		.in_epoch   (s_tdata[59:12]),
		.in_period  (s_tdata[88:60]),
		.in_orbit   (s_tdata[120:89]),
		.in_qtime   (s_tdata[168:121]),
		.cmd        (cmd),
		.st         (st),
		.out_status (out_status),
		.out_orbit  (out_orbit),
		.out_used   (out_used),
		.out_stale  (out_stale)
	);

	assign m_tdata = {1'b0, out_stale, out_used, out_orbit};
	assign m_tuser = out_status;

endmodule
`default_nettype wire

// File: src/onfet_chk.sv
// port level checks for the orbit number from epoch table unit, with bind
// depends on onfet_pkg and orbit_number_from_epoch_table_unit
`default_nettype none
module onfet_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [onfet_pkg::OUT_DW-1:0] m_tdata,
	input wire logic [onfet_pkg::STAT_W-1:0] m_tuser
);
	import onfet_pkg::*;

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in flight");

	// only a computed orbit carries an orbit number and a stale flag
	a_orbit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_ORBIT) |-> (m_tdata[31:0] == '0) && !m_tdata[38])
		else $error("orbit or stale set on a non-orbit result");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// empty, dropped and full results name no entry
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == STAT_EMPTY) || (m_tuser == STAT_DROPPED)
			|| (m_tuser == STAT_FULL)) |-> (m_tdata[37:32] == '0))
		else $error("entry index on a result without an entry");

endmodule

bind orbit_number_from_epoch_table_unit onfet_chk u_chk (.*);
`default_nettype wire
